@@ hdl/arp_pkg.sv @@
package arp_pkg;

	// register widths
	localparam int ZERO_W   = 18;
	localparam int SCALE_W  = 16;
	localparam int LIMIT_W  = 24;
	localparam int DB_W     = 20;

	// field widths
	localparam int TARGET_W = 25;
	localparam int COUNT_W  = 18;
	localparam int ANGLE_W  = 27;
	localparam int DISP_W   = 15;

	// stream word layout, input side
	localparam int IN_USER_W  = 1;
	localparam int IN_DATA_W  = 48;
	localparam int TGT_LSB    = 0;
	localparam int RAW_LSB    = TGT_LSB + TARGET_W;

	// stream word layout, output side
	localparam int OUT_DATA_W = 48;
	localparam int ANGLE_LSB  = 0;
	localparam int DISP_LSB   = ANGLE_LSB + ANGLE_W;
	localparam int UP_BIT     = DISP_LSB + DISP_W;
	localparam int DOWN_BIT   = UP_BIT + 1;
	localparam int BUSY_BIT   = DOWN_BIT + 1;
	localparam int OUT_PAD_W  = OUT_DATA_W - BUSY_BIT - 1;

	// configuration port
	localparam int REG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_COUNT  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_COUNT_SCALE = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ANGLE_LIMIT = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_DEADBAND    = 2'd3;

	// register defaults
	localparam logic [ZERO_W-1:0]  ZERO_RST  = 18'd80751;
	localparam logic [SCALE_W-1:0] SCALE_RST = 16'd35400;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 24'd10813440;
	localparam logic [DB_W-1:0]    DB_RST    = 20'd3277;

	// word kinds
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TARGET = 1'b1;

	// relay state
	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_UP   = 3'b010,
		MODE_DOWN = 3'b100
	} mode_t;

endpackage

@@ hdl/angle_relay_positioner_core.sv @@
// a result word is offered once its input word has passed the input, product, angle and result registers
// throughput: one word per cycle, set by the four register stages (input, product,
// angle, result) that advance independently under back-pressure
// reset: arst_n low clears all valid flags, the relay state, goal and latest angle,
// and loads the default values of the four configuration registers
module angle_relay_positioner_core #(
	parameter int COUNT_BITS = 18,
	parameter int FRAC_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// target_angle[24:0], raw_count[42:25], zero fill
	input  logic [arp_pkg::IN_DATA_W-1:0]   s_tdata,
	// cmd[0]
	input  logic [arp_pkg::IN_USER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// angle_now[26:0], display_tenths[41:27], drive_up[42], drive_down[43],
	// busy_res[44], zero fill
	output logic [arp_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                            cfg_we,
	input  logic [arp_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [arp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import arp_pkg::*;

	localparam int CNT_W       = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;
	localparam int ANGLE_SHIFT = 24 - FRAC_BITS;
	localparam int DIFF_W      = COUNT_W + 1;
	localparam int PROD_W      = DIFF_W + SCALE_W + 1;
	localparam int ERR_W       = ANGLE_W + 1;
	localparam int TEN_W       = ANGLE_W + 4;
	localparam logic [COUNT_W-1:0] COUNT_MASK = COUNT_W'((64'(1) << CNT_W) - 64'(1));
	localparam logic [PROD_W-1:0]  HALF_A     = PROD_W'((64'(1) << ANGLE_SHIFT) >> 1);
	localparam logic [TEN_W-1:0]   HALF_D     = TEN_W'((64'(1) << FRAC_BITS) >> 1);
	localparam logic [PROD_W-1:0]  ANGLE_POS  = PROD_W'((64'(1) << (ANGLE_W - 1)) - 64'(1));
	localparam logic [PROD_W-1:0]  ANGLE_NEG  = PROD_W'(64'(1) << (ANGLE_W - 1));
	localparam logic [TEN_W-1:0]   DISP_POS   = TEN_W'((64'(1) << (DISP_W - 1)) - 64'(1));
	localparam logic [TEN_W-1:0]   DISP_NEG   = TEN_W'(64'(1) << (DISP_W - 1));

	// configuration registers
	logic [ZERO_W-1:0]  zero_q;
	logic [SCALE_W-1:0] scale_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [DB_W-1:0]    db_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q  <= ZERO_RST;
			scale_q <= SCALE_RST;
			limit_q <= LIMIT_RST;
			db_q    <= DB_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ZERO_COUNT:  zero_q  <= cfg_wdata[ZERO_W-1:0];
				REG_COUNT_SCALE: scale_q <= cfg_wdata[SCALE_W-1:0];
				REG_ANGLE_LIMIT: limit_q <= cfg_wdata[LIMIT_W-1:0];
				REG_DEADBAND:    db_q    <= cfg_wdata[DB_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic valid_s1, valid_s2, valid_s3, res_valid_q;
	logic adv_s1, adv_s2, adv_s3, res_ready;

	assign res_ready = !res_valid_q || m_tready;
	assign adv_s3    = !valid_s3 || res_ready;
	assign adv_s2    = !valid_s2 || adv_s3;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign s_tready  = adv_s1;
	assign m_tvalid  = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv_s1)    valid_s1    <= s_tvalid;
			if (adv_s2)    valid_s2    <= valid_s1;
			if (adv_s3)    valid_s3    <= valid_s2;
			if (res_ready) res_valid_q <= valid_s3;
		end
	end

	// input register
	logic                       cmd_s1;
	logic signed [TARGET_W-1:0] target_s1;
	logic [COUNT_W-1:0]         raw_s1;

	always_ff @(posedge clk) begin
		if (s_tvalid && adv_s1) begin
			cmd_s1    <= s_tuser[0];
			target_s1 <= s_tdata[TGT_LSB +: TARGET_W];
			raw_s1    <= s_tdata[RAW_LSB +: COUNT_W];
		end
	end

	// count offset times scale, target clamp
	logic signed [DIFF_W-1:0]    diff_c;
	logic signed [PROD_W-1:0]    prod_c;
	logic signed [TARGET_W:0]    tgt_wide, lim_wide;
	logic signed [TARGET_W-1:0]  goal_c;

	always_comb begin
		diff_c   = $signed({1'b0, raw_s1 & COUNT_MASK}) - $signed({1'b0, zero_q & COUNT_MASK});
		prod_c   = PROD_W'(diff_c) * $signed({{(PROD_W - SCALE_W){1'b0}}, scale_q});
		tgt_wide = (TARGET_W + 1)'(target_s1);
		lim_wide = $signed({2'b00, limit_q});
		if (tgt_wide > lim_wide)
			goal_c = TARGET_W'(lim_wide);
		else if (tgt_wide < -lim_wide)
			goal_c = TARGET_W'(-lim_wide);
		else
			goal_c = target_s1;
	end

	logic                       cmd_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [TARGET_W-1:0] goal_s2;

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s2) begin
			cmd_s2  <= cmd_s1;
			prod_s2 <= prod_c;
			goal_s2 <= goal_c;
		end
	end

	// round to angle, ties away from zero, saturate
	logic                      prod_neg;
	logic [PROD_W-1:0]         prod_mag, angle_mag;
	logic signed [ANGLE_W-1:0] angle_new, angle_c, last_angle_q;

	always_comb begin
		prod_neg  = prod_s2[PROD_W-1];
		prod_mag  = prod_neg ? PROD_W'(-prod_s2) : PROD_W'(prod_s2);
		angle_mag = (prod_mag + HALF_A) >> ANGLE_SHIFT;
		if (prod_neg)
			angle_new = (angle_mag > ANGLE_NEG) ? ANGLE_W'(-ANGLE_NEG)
			                                    : ANGLE_W'(-angle_mag);
		else
			angle_new = (angle_mag > ANGLE_POS) ? ANGLE_W'(ANGLE_POS) : ANGLE_W'(angle_mag);
		angle_c = (cmd_s2 == CMD_SAMPLE) ? angle_new : last_angle_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_angle_q <= '0;
		else if (valid_s2 && adv_s3 && cmd_s2 == CMD_SAMPLE)
			last_angle_q <= angle_new;
	end

	logic                       cmd_s3;
	logic signed [TARGET_W-1:0] goal_s3;
	logic signed [ANGLE_W-1:0]  angle_s3;

	always_ff @(posedge clk) begin
		if (valid_s2 && adv_s3) begin
			cmd_s3   <= cmd_s2;
			goal_s3  <= goal_s2;
			angle_s3 <= angle_c;
		end
	end

	// relay decision
	mode_t                      mode_q, mode_nxt;
	logic signed [TARGET_W-1:0] goal_q, goal_sel;
	logic signed [ERR_W-1:0]    err_c, db_c;

	always_comb begin
		goal_sel = (cmd_s3 == CMD_TARGET) ? goal_s3 : goal_q;
		err_c    = ERR_W'(goal_sel) - ERR_W'(angle_s3);
		db_c     = $signed({{(ERR_W - DB_W){1'b0}}, db_q});
		mode_nxt = MODE_IDLE;
		if (cmd_s3 == CMD_TARGET) begin
			// start rule: zero error or inside the band stays idle
			if (err_c == '0 || (err_c < db_c && err_c > -db_c))
				mode_nxt = MODE_IDLE;
			else if (!err_c[ERR_W-1])
				mode_nxt = MODE_UP;
			else
				mode_nxt = MODE_DOWN;
		end else begin
			unique case (mode_q) inside
				MODE_IDLE: mode_nxt = MODE_IDLE;
				MODE_UP, MODE_DOWN: begin
					// error exactly at the band edge counts as done
					if (err_c > db_c)
						mode_nxt = MODE_UP;
					else if (err_c < -db_c)
						mode_nxt = MODE_DOWN;
					else
						mode_nxt = MODE_IDLE;
				end
				default: mode_nxt = MODE_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			goal_q <= '0;
		end else if (valid_s3 && res_ready) begin
			mode_q <= mode_nxt;
			if (cmd_s3 == CMD_TARGET)
				goal_q <= goal_s3;
		end
	end

	// tenths of a degree, ties away from zero, saturate
	logic                     ang_neg;
	logic [TEN_W-1:0]         ang_mag, ten_mag, disp_mag;
	logic signed [DISP_W-1:0] disp_c;

	always_comb begin
		ang_neg  = angle_s3[ANGLE_W-1];
		ang_mag  = ang_neg ? TEN_W'(-angle_s3) : TEN_W'(angle_s3);
		ang_mag  = {1'b0, ang_mag[TEN_W-2:0]} & TEN_W'({ANGLE_W{1'b1}});
		ten_mag  = (ang_mag << 3) + (ang_mag << 1);
		disp_mag = (ten_mag + HALF_D) >> FRAC_BITS;
		if (ang_neg)
			disp_c = (disp_mag > DISP_NEG) ? DISP_W'(-DISP_NEG) : DISP_W'(-disp_mag);
		else
			disp_c = (disp_mag > DISP_POS) ? DISP_W'(DISP_POS) : DISP_W'(disp_mag);
	end

	// result register
	logic signed [ANGLE_W-1:0] res_angle_q;
	logic signed [DISP_W-1:0]  res_disp_q;
	mode_t                     res_mode_q;

	always_ff @(posedge clk) begin
		if (valid_s3 && res_ready) begin
			res_angle_q <= angle_s3;
			res_disp_q  <= disp_c;
			res_mode_q  <= mode_nxt;
		end
	end

	assign m_tdata = {{OUT_PAD_W{1'b0}},
	                  res_mode_q != MODE_IDLE,
	                  res_mode_q == MODE_DOWN,
	                  res_mode_q == MODE_UP,
	                  res_disp_q,
	                  res_angle_q};

endmodule

@@ hdl/arp_checker.sv @@
module arp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [arp_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import arp_pkg::*;

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// relays never driven together
	a_relay_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[UP_BIT] && m_tdata[DOWN_BIT]))
		else $error("both relays on");

	// busy matches a driven relay
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[BUSY_BIT] == (m_tdata[UP_BIT] || m_tdata[DOWN_BIT]))
		else $error("busy flag disagrees with relays");

	// a non-negative angle never shows a negative display
	a_disp_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[ANGLE_LSB + ANGLE_W - 1] |-> !m_tdata[DISP_LSB + DISP_W - 1])
		else $error("display negative for a non-negative angle");

endmodule

bind angle_relay_positioner_core arp_checker u_arp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
